/* rtl/core/drc_pkg.sv */
// shared types and constants for the column raycaster
`timescale 1ns / 1ps
package drc_pkg;

  localparam int MAP_XW = 5;
  localparam int MAP_YW = 5;
  localparam int MAP_AW = MAP_XW + MAP_YW;
  localparam int MAP_DEPTH = 1 << MAP_AW;
  localparam logic [10:0] SCREEN_MAX = 11'd1024;
  localparam logic [31:0] CAM_START = 32'hFFFF_0000;

  typedef enum logic [2:0] {
    REG_SCREEN_WIDTH  = 3'd0,
    REG_SCREEN_HEIGHT = 3'd1,
    REG_POS_X         = 3'd2,
    REG_POS_Y         = 3'd3,
    REG_DIR_X         = 3'd4,
    REG_DIR_Y         = 3'd5,
    REG_PLANE_X       = 3'd6,
    REG_PLANE_Y       = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIV_DX,
    DIV_DY,
    DIV_LH,
    DIV_ST
  } div_sel_t;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_MUL_X,
    S_RAY_X,
    S_MUL_Y,
    S_RAY_Y,
    S_DX_GO,
    S_DX_WAIT,
    S_DY_GO,
    S_DY_WAIT,
    S_SIDE_X,
    S_SIDE_Y,
    S_STEP,
    S_CHECK,
    S_PERP,
    S_LH_GO,
    S_LH_WAIT,
    S_ST_GO,
    S_ST_WAIT,
    S_FIN
  } state_t;

  typedef struct packed {
    logic     load;
    logic     clear_wr;
    logic     mul_x;
    logic     ray_x;
    logic     mul_y;
    logic     ray_y;
    logic     div_start;
    div_sel_t div_sel;
    logic     take_dx;
    logic     take_dy;
    logic     side_x;
    logic     side_y;
    logic     walk_step;
    logic     hit_capture;
    logic     perp_calc;
    logic     take_lh;
    logic     take_step;
    logic     out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic rx_zero;
    logic ry_zero;
    logic div_busy;
    logic div_done;
    logic walk_done;
  } dp_stat_t;

endpackage

/* rtl/core/drc_div.sv */
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module drc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [32:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [32:0] quotient
);

  logic [32:0] quo;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [5:0]  cnt;
  logic [32:0] trial;
  logic        fits;

  assign trial = {rem, quo[32]};
  assign fits = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd32) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= {quo[31:0], fits};
      rem <= fits ? 32'(trial - {1'b0, dvs}) : trial[31:0];
    end
  end

endmodule

/* rtl/core/drc_ctrl.sv */
// sequencer for map writes and column casts
`timescale 1ns / 1ps
module drc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              action,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output drc_pkg::dp_cmd_t  cmd,
  input  drc_pkg::dp_stat_t stat
);
  import drc_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clear_wr = 1'b1;
        if (stat.clear_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (action) state_next = S_MUL_X;
        end
      end
      S_MUL_X: begin
        cmd.mul_x = 1'b1;
        state_next = S_RAY_X;
      end
      S_RAY_X: begin
        cmd.ray_x = 1'b1;
        state_next = S_MUL_Y;
      end
      S_MUL_Y: begin
        cmd.mul_y = 1'b1;
        state_next = S_RAY_Y;
      end
      S_RAY_Y: begin
        cmd.ray_y = 1'b1;
        state_next = S_DX_GO;
      end
      S_DX_GO: begin
        cmd.div_sel = DIV_DX;
        if (stat.rx_zero) begin
          cmd.take_dx = 1'b1;
          state_next = S_DY_GO;
        end else begin
          cmd.div_start = 1'b1;
          state_next = S_DX_WAIT;
        end
      end
      S_DX_WAIT: begin
        if (stat.div_done) begin
          cmd.take_dx = 1'b1;
          state_next = S_DY_GO;
        end
      end
      S_DY_GO: begin
        cmd.div_sel = DIV_DY;
        if (stat.ry_zero) begin
          cmd.take_dy = 1'b1;
          state_next = S_SIDE_X;
        end else begin
          cmd.div_start = 1'b1;
          state_next = S_DY_WAIT;
        end
      end
      S_DY_WAIT: begin
        if (stat.div_done) begin
          cmd.take_dy = 1'b1;
          state_next = S_SIDE_X;
        end
      end
      S_SIDE_X: begin
        cmd.side_x = 1'b1;
        state_next = S_SIDE_Y;
      end
      S_SIDE_Y: begin
        cmd.side_y = 1'b1;
        state_next = S_STEP;
      end
      S_STEP: begin
        cmd.walk_step = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (stat.walk_done) begin
          cmd.hit_capture = 1'b1;
          state_next = S_PERP;
        end else begin
          state_next = S_STEP;
        end
      end
      S_PERP: begin
        cmd.perp_calc = 1'b1;
        state_next = S_LH_GO;
      end
      S_LH_GO: begin
        cmd.div_sel = DIV_LH;
        cmd.div_start = 1'b1;
        state_next = S_LH_WAIT;
      end
      S_LH_WAIT: begin
        if (stat.div_done) begin
          cmd.take_lh = 1'b1;
          state_next = S_ST_GO;
        end
      end
      S_ST_GO: begin
        cmd.div_sel = DIV_ST;
        cmd.div_start = 1'b1;
        state_next = S_ST_WAIT;
      end
      S_ST_WAIT: begin
        if (stat.div_done) begin
          cmd.take_step = 1'b1;
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* rtl/core/drc_datapath.sv */
// registers, map store, multipliers and divider of the raycaster
`timescale 1ns / 1ps
module drc_datapath (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [2:0]        cfg_index,
  input  logic [20:0]       cfg_data,
  input  logic              action,
  input  logic [4:0]        cell_x,
  input  logic [4:0]        cell_y,
  input  logic [7:0]        cell_value,
  input  logic [9:0]        column,
  input  drc_pkg::dp_cmd_t  cmd,
  output drc_pkg::dp_stat_t stat,
  output logic [9:0]        out_column,
  output logic [9:0]        slice_top,
  output logic [9:0]        slice_bottom,
  output logic [7:0]        wall_value,
  output logic              hit_side,
  output logic              outside
);
  import drc_pkg::*;

  // configuration
  logic [10:0]        screen_width, screen_height;
  logic [20:0]        pos_x, pos_y;
  logic signed [18:0] dir_x, dir_y, plane_x, plane_y;

  always_ff @(posedge clk) begin
    if (rst) begin
      screen_width  <= 11'd320;
      screen_height <= 11'd240;
      pos_x   <= 21'd131072;
      pos_y   <= 21'd131072;
      dir_x   <= -19'sd65536;
      dir_y   <= '0;
      plane_x <= '0;
      plane_y <= 19'sd43253;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_SCREEN_WIDTH:  screen_width  <= cfg_data[10:0];
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[10:0];
        REG_POS_X:         pos_x   <= cfg_data;
        REG_POS_Y:         pos_y   <= cfg_data;
        REG_DIR_X:         dir_x   <= cfg_data[18:0];
        REG_DIR_Y:         dir_y   <= cfg_data[18:0];
        REG_PLANE_X:       plane_x <= cfg_data[18:0];
        REG_PLANE_Y:       plane_y <= cfg_data[18:0];
        default: ;
      endcase
    end
  end

  logic [10:0] w_clamp, h_clamp;
  assign w_clamp = (screen_width == 11'd0) ? 11'd1 :
                   (screen_width > SCREEN_MAX) ? SCREEN_MAX : screen_width;
  assign h_clamp = (screen_height == 11'd0) ? 11'd1 :
                   (screen_height > SCREEN_MAX) ? SCREEN_MAX : screen_height;

  // camera accumulator and ray
  logic [31:0]        cam;
  logic [9:0]         column_r;
  logic signed [50:0] prod;
  logic signed [31:0] rx, ry;
  logic signed [31:0] fm;
  logic signed [32:0] ray_sum;
  logic signed [31:0] ray_sat;
  logic signed [18:0] mul_a;
  logic signed [18:0] dir_sel;
  logic [32:0]        div_q;

  assign mul_a = cmd.mul_y ? plane_y : plane_x;
  assign dir_sel = cmd.ray_y ? dir_y : dir_x;

  always_comb begin
    if (prod[50:47] == 4'h0 || prod[50:47] == 4'hF) begin
      fm = prod[47:16];
    end else begin
      fm = prod[50] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end
    ray_sum = 33'(dir_sel) + 33'(fm);
    if (ray_sum[32] != ray_sum[31]) begin
      ray_sat = ray_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      ray_sat = ray_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cam <= CAM_START;
    end else if (cmd.load && action && column == 10'd0) begin
      cam <= CAM_START;
    end else if (cmd.take_step) begin
      cam <= cam + 32'(div_q[17:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) column_r <= column;
    if (cmd.mul_x || cmd.mul_y) prod <= 51'(mul_a) * 51'($signed(cam));
    if (cmd.ray_x) rx <= ray_sat;
    if (cmd.ray_y) ry <= ray_sat;
  end

  // divider operands
  logic [31:0] rx_abs, ry_abs;
  logic [32:0] div_dividend;
  logic [31:0] div_divisor;
  logic [30:0] q_sat;
  logic [30:0] perp;
  logic        div_busy, div_done;

  assign rx_abs = rx[31] ? (~rx + 32'd1) : rx;
  assign ry_abs = ry[31] ? (~ry + 32'd1) : ry;
  assign q_sat = (div_q[32:31] != 2'b00) ? 31'h7FFF_FFFF : div_q[30:0];

  always_comb begin
    case (cmd.div_sel)
      DIV_DX: begin
        div_dividend = 33'h1_0000_0000;
        div_divisor  = rx_abs;
      end
      DIV_DY: begin
        div_dividend = 33'h1_0000_0000;
        div_divisor  = ry_abs;
      end
      DIV_LH: begin
        div_dividend = {6'd0, h_clamp, 16'd0};
        div_divisor  = {1'b0, perp};
      end
      DIV_ST: begin
        div_dividend = 33'h2_0000;
        div_divisor  = {21'd0, w_clamp};
      end
      default: begin
        div_dividend = '0;
        div_divisor  = 32'd1;
      end
    endcase
  end

  drc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // grid walk
  logic [30:0] dx, dy, sx, sy;
  logic [5:0]  mx, my, mx_next, my_next;
  logic        stx_neg, sty_neg, side;
  logic [16:0] frac_x, frac_y;
  logic [47:0] side_prod_x, side_prod_y;
  logic        step_x;
  logic [31:0] sx_sum, sy_sum;
  logic        out_now;

  assign frac_x = rx[31] ? {1'b0, pos_x[15:0]} : 17'h1_0000 - {1'b0, pos_x[15:0]};
  assign frac_y = ry[31] ? {1'b0, pos_y[15:0]} : 17'h1_0000 - {1'b0, pos_y[15:0]};
  assign side_prod_x = 48'(frac_x) * 48'(dx);
  assign side_prod_y = 48'(frac_y) * 48'(dy);
  assign step_x = sx < sy;
  assign sx_sum = {1'b0, sx} + {1'b0, dx};
  assign sy_sum = {1'b0, sy} + {1'b0, dy};
  assign mx_next = (cmd.walk_step && step_x) ? (stx_neg ? mx - 6'd1 : mx + 6'd1) : mx;
  assign my_next = (cmd.walk_step && !step_x) ? (sty_neg ? my - 6'd1 : my + 6'd1) : my;
  // the top index bit marks one step past either edge
  assign out_now = mx[MAP_XW] | my[MAP_YW];

  always_ff @(posedge clk) begin
    if (cmd.take_dx) dx <= (rx == 32'sd0) ? 31'h7FFF_FFFF : q_sat;
    if (cmd.take_dy) dy <= (ry == 32'sd0) ? 31'h7FFF_FFFF : q_sat;
    if (cmd.side_x) begin
      sx      <= side_prod_x[46:16];
      mx      <= {1'b0, pos_x[20:16]};
      stx_neg <= rx[31];
    end
    if (cmd.side_y) begin
      sy      <= side_prod_y[46:16];
      my      <= {1'b0, pos_y[20:16]};
      sty_neg <= ry[31];
    end
    if (cmd.walk_step) begin
      mx <= mx_next;
      my <= my_next;
      side <= !step_x;
      if (step_x) begin
        sx <= sx_sum[31] ? 31'h7FFF_FFFF : sx_sum[30:0];
      end else begin
        sy <= sy_sum[31] ? 31'h7FFF_FFFF : sy_sum[30:0];
      end
    end
  end

  // map store
  logic [7:0]        map_mem [MAP_DEPTH];
  logic [MAP_AW-1:0] clear_addr, wr_addr, rd_addr;
  logic [7:0]        wr_data, rd_data;
  logic              wr_en;

  assign wr_en = cmd.clear_wr | (cmd.load & ~action);
  assign wr_addr = cmd.clear_wr ? clear_addr : {cell_x, cell_y};
  assign wr_data = cmd.clear_wr ? 8'd0 : cell_value;
  assign rd_addr = {mx_next[MAP_XW-1:0], my_next[MAP_YW-1:0]};

  always_ff @(posedge clk) begin
    if (wr_en) map_mem[wr_addr] <= wr_data;
    rd_data <= map_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clear_addr <= '0;
    end else if (cmd.clear_wr) begin
      clear_addr <= clear_addr + MAP_AW'(1);
    end
  end

  // hit, distance and slice
  logic [7:0]  value_r;
  logic        outside_r;
  logic signed [31:0] perp_diff;
  logic [25:0] lh_half;
  logic [9:0]  h_half;
  logic [26:0] de_sum;
  logic [9:0]  ds_r, de_r;

  assign perp_diff = side ? $signed({1'b0, sy} - {1'b0, dy})
                          : $signed({1'b0, sx} - {1'b0, dx});
  assign lh_half = div_q[26:1];
  assign h_half = h_clamp[10:1];
  assign de_sum = {1'b0, lh_half} + 27'(h_half);

  always_ff @(posedge clk) begin
    if (cmd.hit_capture) begin
      value_r   <= out_now ? 8'd0 : rd_data;
      outside_r <= out_now;
    end
    if (cmd.perp_calc) begin
      perp <= (perp_diff <= 32'sd0) ? 31'd1 : perp_diff[30:0];
    end
    if (cmd.take_lh) begin
      ds_r <= (lh_half > 26'(h_half)) ? 10'd0 : h_half - lh_half[9:0];
      de_r <= (de_sum >= 27'(h_clamp)) ? 10'(h_clamp - 11'd1) : de_sum[9:0];
    end
    if (cmd.out_load) begin
      out_column   <= column_r;
      slice_top    <= ds_r;
      slice_bottom <= de_r;
      wall_value   <= value_r;
      hit_side     <= side;
      outside      <= outside_r;
    end
  end

  always_comb begin
    stat = '0;
    stat.clear_last = clear_addr == {MAP_AW{1'b1}};
    stat.rx_zero    = rx == 32'sd0;
    stat.ry_zero    = ry == 32'sd0;
    stat.div_busy   = div_busy;
    stat.div_done   = div_done;
    stat.walk_done  = out_now | (rd_data != 8'd0);
  end

endmodule

/* rtl/core/dda_raycast_column.sv */
// top level of the grid raycaster that renders one screen column per cast
`timescale 1ns / 1ps
// usage
//   input channel (in_valid/in_ready): action 0 stores cell_value at
//   (cell_x, cell_y) in the 32x32 map, action 1 casts screen column
//   'column'; column 0 restarts the camera sweep at -1.0
//   output channel (out_valid/out_ready): one transaction per cast with the
//   clipped wall slice, hit cell code, side crossed and an outside flag
//   config channel (cfg_valid/cfg_ready, always ready): cfg_index picks the
//   register, cfg_data carries its value; write only while the block is idle
// timing
//   a map write is stored as it is taken and the block stays ready; a cast's
//   length is set by up to four passes through the one-bit-per-cycle
//   divider (two ray deltas, line height, camera step) and the map read in
//   each walk step; one cast is in flight at a time
// reset
//   rst clears control and restores register defaults, then all 1024 map
//   cells are swept to zero while in_ready stays low
// stalls
//   a finished slice waits in the output register; the next item is still
//   taken, and a second finished cast holds until out_ready frees the slot
module dda_raycast_column (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        action,
  input  logic [4:0]  cell_x,
  input  logic [4:0]  cell_y,
  input  logic [7:0]  cell_value,
  input  logic [9:0]  column,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_column,
  output logic [9:0]  slice_top,
  output logic [9:0]  slice_bottom,
  output logic [7:0]  wall_value,
  output logic        hit_side,
  output logic        outside,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [20:0] cfg_data
);
  import drc_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // registers take a write in any cycle
  assign cfg_ready = 1'b1;

  // sequencer issues one command group per cycle
  drc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .action    (action),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // datapath holds config, map store, ray math and the output slot
  drc_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .action       (action),
    .cell_x       (cell_x),
    .cell_y       (cell_y),
    .cell_value   (cell_value),
    .column       (column),
    .cmd          (cmd),
    .stat         (stat),
    .out_column   (out_column),
    .slice_top    (slice_top),
    .slice_bottom (slice_bottom),
    .wall_value   (wall_value),
    .hit_side     (hit_side),
    .outside      (outside)
  );

  // map clear runs after every reset before any item is taken
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input taken during map clear");

  // a cast occupies the block until its slice is produced
  a_cast_blocks: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && action |=> !in_ready)
    else $error("input taken while a cast is in flight");

  // a new slice only appears from the sequencer's output load
  a_out_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(cmd.out_load))
    else $error("output valid without a load");

  // the divider is never restarted mid-operation
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider started while busy");

endmodule

/* tb/sv/dda_raycast_column_checker.sv */
// checker that mirrors the raycaster state, predicts every column slice and compares it
`timescale 1ns / 1ps
module dda_raycast_column_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        action,
  input  logic [4:0]  cell_x,
  input  logic [4:0]  cell_y,
  input  logic [7:0]  cell_value,
  input  logic [9:0]  column,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [9:0]  out_column,
  input  logic [9:0]  slice_top,
  input  logic [9:0]  slice_bottom,
  input  logic [7:0]  wall_value,
  input  logic        hit_side,
  input  logic        outside,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [20:0] cfg_data,
  output int          fail_count,
  output int          slices_pending,
  output int          slices_checked
);
  import drc_pkg::*;

  localparam longint ONE_Q = 65536;
  localparam longint INF_Q = 64'sd2147483647;

  typedef struct {
    logic [9:0] col;
    logic [9:0] ds;
    logic [9:0] de;
    logic [7:0] val;
    logic       side;
    logic       outf;
  } slice_t;

  slice_t      slice_q[$];
  logic [7:0]  cell_map[32][32];
  logic [31:0] cam_acc;
  logic [10:0] width_r, height_r;
  logic [20:0] pos_x_r, pos_y_r;
  logic [18:0] dir_x_r, dir_y_r, plane_x_r, plane_y_r;

  function automatic longint sat32(longint v);
    if (v > INF_Q) return INF_Q;
    if (v < -INF_Q - 1) return -INF_Q - 1;
    return v;
  endfunction

  // q16.16 product, floor rounding
  function automatic longint qmul(longint a, longint b);
    return sat32((a * b) >>> 16);
  endfunction

  function automatic longint ray_delta(longint r);
    if (r == 0) return INF_Q;
    return sat32(64'sd4294967296 / (r < 0 ? -r : r));
  endfunction

  function automatic longint clamp_scr(logic [10:0] v);
    if (v < 1) return 1;
    if (v > SCREEN_MAX) return 1024;
    return longint'(v);
  endfunction

  function automatic slice_t cast_column(logic [9:0] col);
    longint w, h, cam, rx, ry, px, py, dx, dy, sx, sy, perp, lh, ds, de;
    int mx, my, stx, sty;
    logic side, outf;
    logic [7:0] val;
    slice_t s;
    side = 0;
    outf = 0;
    val = 0;
    w = clamp_scr(width_r);
    h = clamp_scr(height_r);
    if (col == 0) cam_acc = CAM_START;
    cam = longint'($signed(cam_acc));
    rx = sat32(longint'($signed(dir_x_r)) + qmul(longint'($signed(plane_x_r)), cam));
    ry = sat32(longint'($signed(dir_y_r)) + qmul(longint'($signed(plane_y_r)), cam));
    px = longint'(pos_x_r);
    py = longint'(pos_y_r);
    mx = int'(pos_x_r >> 16);
    my = int'(pos_y_r >> 16);
    dx = ray_delta(rx);
    dy = ray_delta(ry);
    if (rx < 0) begin
      stx = -1;
      sx = qmul(px - longint'(mx) * ONE_Q, dx);
    end else begin
      stx = 1;
      sx = qmul(longint'(mx) * ONE_Q + ONE_Q - px, dx);
    end
    if (ry < 0) begin
      sty = -1;
      sy = qmul(py - longint'(my) * ONE_Q, dy);
    end else begin
      sty = 1;
      sy = qmul(longint'(my) * ONE_Q + ONE_Q - py, dy);
    end
    // dda walk, the viewer cell itself is skipped
    forever begin
      if (sx < sy) begin
        sx = sat32(sx + dx);
        mx += stx;
        side = 0;
      end else begin
        sy = sat32(sy + dy);
        my += sty;
        side = 1;
      end
      if (mx < 0 || mx >= 32 || my < 0 || my >= 32) begin
        outf = 1;
        val = 0;
        break;
      end
      val = cell_map[mx][my];
      if (val != 0) break;
    end
    perp = side ? sat32(sy - dy) : sat32(sx - dx);
    if (perp <= 0) perp = 1;
    lh = sat32((h * ONE_Q) / perp);
    ds = h / 2 - lh / 2;
    if (ds < 0) ds = 0;
    de = lh / 2 + h / 2;
    if (de >= h) de = h - 1;
    s.col = col;
    s.ds = ds[9:0];
    s.de = de[9:0];
    s.val = val;
    s.side = side;
    s.outf = outf;
    cam_acc = cam_acc + 32'((2 * ONE_Q) / w);
    return s;
  endfunction

  always @(posedge clk) begin
    slice_t e;
    if (rst) begin
      foreach (cell_map[i, j]) cell_map[i][j] = 8'd0;
      cam_acc = CAM_START;
      width_r = 11'd320;
      height_r = 11'd240;
      pos_x_r = 21'd131072;
      pos_y_r = 21'd131072;
      dir_x_r = 19'h70000;
      dir_y_r = 19'd0;
      plane_x_r = 19'd0;
      plane_y_r = 19'd43253;
      slice_q.delete();
      fail_count = 0;
      slices_checked = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_SCREEN_WIDTH:  width_r = cfg_data[10:0];
          REG_SCREEN_HEIGHT: height_r = cfg_data[10:0];
          REG_POS_X:         pos_x_r = cfg_data;
          REG_POS_Y:         pos_y_r = cfg_data;
          REG_DIR_X:         dir_x_r = cfg_data[18:0];
          REG_DIR_Y:         dir_y_r = cfg_data[18:0];
          REG_PLANE_X:       plane_x_r = cfg_data[18:0];
          REG_PLANE_Y:       plane_y_r = cfg_data[18:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (action) slice_q.push_back(cast_column(column));
        else cell_map[cell_x][cell_y] = cell_value;
      end
      if (out_valid && out_ready) begin
        if (slice_q.size() == 0) begin
          $display("%0t: slice for column %0d with no cast waiting", $time, out_column);
          fail_count++;
        end else begin
          e = slice_q.pop_front();
          slices_checked++;
          if (out_column !== e.col) begin
            $display("%0t: out_column exp %0d got %0d", $time, e.col, out_column);
            fail_count++;
          end
          if (slice_top !== e.ds) begin
            $display("%0t: slice_top col %0d exp %0d got %0d", $time, e.col, e.ds, slice_top);
            fail_count++;
          end
          if (slice_bottom !== e.de) begin
            $display("%0t: slice_bottom col %0d exp %0d got %0d", $time, e.col, e.de,
                     slice_bottom);
            fail_count++;
          end
          if (wall_value !== e.val) begin
            $display("%0t: wall_value col %0d exp %0d got %0d", $time, e.col, e.val,
                     wall_value);
            fail_count++;
          end
          if (hit_side !== e.side) begin
            $display("%0t: hit_side col %0d exp %0d got %0d", $time, e.col, e.side, hit_side);
            fail_count++;
          end
          if (outside !== e.outf) begin
            $display("%0t: outside col %0d exp %0d got %0d", $time, e.col, e.outf, outside);
            fail_count++;
          end
        end
      end
    end
    slices_pending = slice_q.size();
  end

endmodule

/* tb/sv/dda_raycast_column_test.sv */
// top of the raycaster testbench: stimulus, stalls and the verdict
`timescale 1ns / 1ps
module dda_raycast_column_test;
  import drc_pkg::*;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic        action;
  logic [4:0]  cell_x;
  logic [4:0]  cell_y;
  logic [7:0]  cell_value;
  logic [9:0]  column;
  logic        out_valid;
  logic        out_ready;
  logic [9:0]  out_column;
  logic [9:0]  slice_top;
  logic [9:0]  slice_bottom;
  logic [7:0]  wall_value;
  logic        hit_side;
  logic        outside;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [20:0] cfg_data;

  int fail_count, slices_pending, slices_checked;
  int snd_idle_pct, rcv_idle_pct;
  int n_casts, n_writes, n_cfg;
  logic [9:0] sweep_col;

  dda_raycast_column uut (.*);

  dda_raycast_column_checker chk (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .action(action),
    .cell_x(cell_x), .cell_y(cell_y), .cell_value(cell_value), .column(column),
    .out_valid(out_valid), .out_ready(out_ready), .out_column(out_column),
    .slice_top(slice_top), .slice_bottom(slice_bottom), .wall_value(wall_value),
    .hit_side(hit_side), .outside(outside), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .fail_count(fail_count),
    .slices_pending(slices_pending), .slices_checked(slices_checked)
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #20000000;
    $display("timeout with %0d slices outstanding", slices_pending);
    $display("Verification failed");
    $finish;
  end

  // receiver stalls at random per the current idling mode
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // one input transaction; valid only drops when a gap is inserted
  task automatic send_item(logic act, logic [4:0] cx, logic [4:0] cy, logic [7:0] cv,
                           logic [9:0] col);
    if ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < snd_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    cell_x <= cx;
    cell_y <= cy;
    cell_value <= cv;
    column <= col;
    forever begin
      @(negedge clk);
      if (in_ready) break;
    end
    @(posedge clk);
    if (act) n_casts++;
    else n_writes++;
  endtask

  task automatic map_write(logic [4:0] cx, logic [4:0] cy, logic [7:0] cv);
    send_item(1'b0, cx, cy, cv, 10'($urandom));
  endtask

  task automatic cast(logic [9:0] col);
    send_item(1'b1, 5'($urandom), 5'($urandom), 8'($urandom), col);
  endtask

  // drain every outstanding slice, then let the block settle before config changes
  task automatic drain;
    in_valid <= 1'b0;
    while (slices_pending != 0) @(negedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 21'(val);
    forever begin
      @(negedge clk);
      if (cfg_ready) break;
    end
    @(posedge clk);
    n_cfg++;
  endtask

  // program all eight registers; setting 4 is a random pose
  task automatic load_setting(int sel);
    int v[8];
    case (sel)
      0: v = '{320, 240, 131072, 131072, -65536, 0, 0, 43253};
      1: v = '{1, 1, 0, 0, 131072, 131072, -131072, 131072};
      2: v = '{1024, 1024, 2097151, 2097151, -131072, -131072, 131072, -131072};
      3: v = '{0, 2047, 32'h108000, 32'h54000, 0, 65536, 43253, 0};
      default: begin
        v[0] = $urandom_range(1024, 1);
        v[1] = $urandom_range(1024, 1);
        v[2] = $urandom_range(2097151);
        v[3] = $urandom_range(2097151);
        for (int i = 4; i < 8; i++) v[i] = int'($urandom_range(262144)) - 131072;
      end
    endcase
    for (int i = 0; i < 8; i++) cfg_write(cfg_reg_t'(i), v[i]);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    action = 1'b0;
    cell_x = '0;
    cell_y = '0;
    cell_value = '0;
    column = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    n_casts = 0;
    n_writes = 0;
    n_cfg = 0;
    snd_idle_pct = 19;
    rcv_idle_pct = 78;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed: empty map runs out of bounds, then walls at the extremes
    cast(10'd0);
    cast(10'd1023);
    map_write(5'd1, 5'd2, 8'd9);      // wall right on the viewer's grid line, zero distance
    cast(10'd0);
    map_write(5'd1, 5'd2, 8'd0);      // cleared again
    map_write(5'd0, 5'd0, 8'd255);
    map_write(5'd31, 5'd31, 8'd1);
    map_write(5'd0, 5'd2, 8'd128);
    map_write(5'd2, 5'd2, 8'd7);      // viewer's own cell, never tested
    cast(10'd0);
    cast(10'd1);
    cast(10'd160);
    cast(10'd319);
    cast(10'd511);
    drain();
    load_setting(1);
    cast(10'd5);
    cast(10'd0);
    drain();
    load_setting(2);
    cast(10'd0);
    cast(10'd1023);
    drain();
    load_setting(3);
    cast(10'd0);
    cast(10'd2);

    // random part: nine phases across the three idling modes
    for (int ph = 0; ph < 9; ph++) begin
      drain();
      if (ph == 3) begin
        snd_idle_pct = 78;
        rcv_idle_pct = 19;
      end else if (ph == 6) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      load_setting((ph == 0) ? 0 : ((ph % 5 == 0) ? 4 : ph % 5));
      sweep_col = 10'd0;
      for (int k = 0; k < 150; k++) begin
        if ($urandom_range(99) < 30) begin
          map_write(5'($urandom), 5'($urandom),
                    ($urandom_range(1) == 0) ? 8'd0 : 8'($urandom));
        end else if ($urandom_range(99) < 80) begin
          // mostly a sweep across the frame
          cast(sweep_col);
          sweep_col = ($urandom_range(19) == 0) ? 10'd0 : sweep_col + 10'd1;
        end else begin
          cast(10'($urandom));
        end
      end
    end
    drain();

    $display("casts %0d, map writes %0d, register writes %0d, slices checked %0d",
             n_casts, n_writes, n_cfg, slices_checked);
    $display("covered empty and walled maps, edge poses, screen clamps and three stall mixes");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
